[sv/ifhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhc_pkg
// Shared types and constants of the frame header checker: header layout,
// status codes and the per-byte header check result.
// ----------------------------------------------------------------------------
package ifhc_pkg;

    // Header layout
    localparam int HEADER_BYTES = 12;
    localparam int HDR_POS_W    = $clog2(HEADER_BYTES);
    localparam int VERSION_POS  = 4;
    localparam int TYPE_POS     = 5;
    localparam int RSV_POS      = 6;
    localparam int LEN_POS      = 8;

    // Field widths
    localparam int LEN_W = 25;

    // Constants
    localparam logic [7:0] VERSION_ONE  = 8'h01;
    localparam logic [7:0] TYPE_REQUEST = 8'h01;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 25'd16777216;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_MAGIC    = 3'd1,
        ST_VERSION  = 3'd2,
        ST_TYPE     = 3'd3,
        ST_RESERVED = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_LARGE    = 3'd6,
        ST_EXTRA    = 3'd7
    } status_t;

    // Magic word, one byte per header position 0..3
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h59;
            2'd1:    b = 8'h49;
            2'd2:    b = 8'h33;
            default: b = 8'h44;
        endcase
        return b;
    endfunction

    // Outcome of checking one header byte
    typedef struct packed {
        status_t          fault;      // first fault so far, ST_DATA if none
        logic [23:0]      len_acc;    // length bytes collected so far
        logic [LEN_W-1:0] frame_len;  // payload length, valid on the last byte
    } hdr_step_t;

    // One result item
    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] payload_byte;
        logic       is_last;
    } result_t;

endpackage

[sv/ifhc_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhc channels
// Valid/ready channels: received bytes in, result items out.
// ----------------------------------------------------------------------------
interface ifhc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface ifhc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic       is_last;

    modport source (output valid, output status, output payload_byte, output is_last,
                    input ready);
    modport sink   (input valid, input status, input payload_byte, input is_last,
                    output ready);
endinterface

[sv/ifhc_hdr_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhc_hdr_check
// Checks one header byte at its position, keeps the first fault and
// collects the big-endian length; on the last byte it checks the length.
// ----------------------------------------------------------------------------
module ifhc_hdr_check (
    input  logic [ifhc_pkg::HDR_POS_W-1:0] pos,
    input  logic [7:0]                     rx_byte,
    input  ifhc_pkg::status_t              fault_in,
    input  logic [23:0]                    len_in,
    input  logic [ifhc_pkg::LEN_W-1:0]     max_payload,
    output ifhc_pkg::hdr_step_t            step
);

    ifhc_pkg::status_t byte_fault;
    ifhc_pkg::status_t prior;
    logic [31:0]       len_full;

    // fault of this byte alone
    always_comb
    begin
        byte_fault = ifhc_pkg::ST_DATA;
        if (pos < ifhc_pkg::HDR_POS_W'(ifhc_pkg::VERSION_POS))
        begin
            if (rx_byte != ifhc_pkg::magic_byte(pos[1:0]))
                byte_fault = ifhc_pkg::ST_MAGIC;
        end
        else if (pos == ifhc_pkg::HDR_POS_W'(ifhc_pkg::VERSION_POS))
        begin
            if (rx_byte != ifhc_pkg::VERSION_ONE)
                byte_fault = ifhc_pkg::ST_VERSION;
        end
        else if (pos == ifhc_pkg::HDR_POS_W'(ifhc_pkg::TYPE_POS))
        begin
            if (rx_byte != ifhc_pkg::TYPE_REQUEST)
                byte_fault = ifhc_pkg::ST_TYPE;
        end
        else if (pos < ifhc_pkg::HDR_POS_W'(ifhc_pkg::LEN_POS))
        begin
            if (rx_byte != 8'd0)
                byte_fault = ifhc_pkg::ST_RESERVED;
        end
    end

    // first fault wins; a new header starts clean
    assign prior    = (pos == '0) ? ifhc_pkg::ST_DATA : fault_in;
    assign len_full = {len_in, rx_byte};

    always_comb
    begin
        step.fault     = (prior != ifhc_pkg::ST_DATA) ? prior : byte_fault;
        step.len_acc   = len_in;
        step.frame_len = len_full[ifhc_pkg::LEN_W-1:0];
        if (pos == ifhc_pkg::HDR_POS_W'(ifhc_pkg::LEN_POS))
            step.len_acc = {16'd0, rx_byte};
        else if (pos > ifhc_pkg::HDR_POS_W'(ifhc_pkg::LEN_POS))
            step.len_acc = {len_in[15:0], rx_byte};
        // length checks on the last header byte
        if (pos == ifhc_pkg::HDR_POS_W'(ifhc_pkg::HEADER_BYTES - 1)
            && step.fault == ifhc_pkg::ST_DATA)
        begin
            if (len_full == 32'd0)
                step.fault = ifhc_pkg::ST_EMPTY;
            else if (len_full > {7'd0, max_payload})
                step.fault = ifhc_pkg::ST_LARGE;
        end
    end

endmodule

[sv/ifhc_frame_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhc_frame_fsm
// Frame parser: header collection, payload count, frame end and drop
// phases; holds the length limit register and forms at most one result per byte.
// ----------------------------------------------------------------------------
module ifhc_frame_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ifhc_pkg::LEN_W-1:0]     cfg_wdata,
    input  logic                           accept,
    input  logic                           action,
    input  logic [7:0]                     rx_byte,
    output ifhc_pkg::result_t              result
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2,
        PH_DROP    = 2'd3
    } phase_t;

    localparam logic [ifhc_pkg::HDR_POS_W-1:0] LAST_POS =
        ifhc_pkg::HDR_POS_W'(ifhc_pkg::HEADER_BYTES - 1);

    phase_t                          phase_reg, phase_next;
    logic [ifhc_pkg::HDR_POS_W-1:0]  pos_reg, pos_next;
    logic [ifhc_pkg::LEN_W-1:0]      remain_reg, remain_next;
    logic [ifhc_pkg::LEN_W-1:0]      remain_dec;
    ifhc_pkg::status_t               fault_reg, fault_next;
    logic [23:0]                     len_reg, len_next;
    logic [ifhc_pkg::LEN_W-1:0]      max_reg;
    ifhc_pkg::hdr_step_t             step;

    // per-byte header check
    ifhc_hdr_check u_hdr_check (
        .pos         (pos_reg),
        .rx_byte     (rx_byte),
        .fault_in    (fault_reg),
        .len_in      (len_reg),
        .max_payload (max_reg),
        .step        (step)
    );

    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    // next state and result for an accepted transaction
    always_comb
    begin
        phase_next          = phase_reg;
        pos_next            = pos_reg;
        remain_next         = remain_reg;
        fault_next          = fault_reg;
        len_next            = len_reg;
        result.valid        = 1'b0;
        result.status       = ifhc_pkg::ST_DATA;
        result.payload_byte = 8'd0;
        result.is_last      = 1'b0;
        if (accept)
        begin
            if (action)
            begin
                phase_next  = PH_HEADER;
                pos_next    = '0;
                remain_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        fault_next = step.fault;
                        len_next   = step.len_acc;
                        if (pos_reg == LAST_POS)
                        begin
                            pos_next = '0;
                            if (step.fault != ifhc_pkg::ST_DATA)
                            begin
                                phase_next    = PH_DROP;
                                result.valid  = 1'b1;
                                result.status = step.fault;
                            end
                            else
                            begin
                                phase_next  = PH_PAYLOAD;
                                remain_next = step.frame_len;
                            end
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                    PH_PAYLOAD:
                    begin
                        remain_next         = remain_dec;
                        result.valid        = 1'b1;
                        result.payload_byte = rx_byte;
                        result.is_last      = (remain_dec == '0);
                        if (remain_dec == '0)
                            phase_next = PH_DONE;
                    end
                    PH_DONE:
                    begin
                        phase_next    = PH_DROP;
                        result.valid  = 1'b1;
                        result.status = ifhc_pkg::ST_EXTRA;
                    end
                    default:
                    begin
                        phase_next = PH_DROP;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            remain_reg <= '0;
            fault_reg  <= ifhc_pkg::ST_DATA;
            max_reg    <= ifhc_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            fault_reg  <= fault_next;
            if (cfg_we)
                max_reg <= cfg_wdata;
        end
    end

    // length bytes, no reset needed
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("header position out of range");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with no bytes left");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.is_last |=> phase_reg == PH_DONE)
        else $error("last payload byte did not end the frame");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != ifhc_pkg::ST_DATA |=> phase_reg == PH_DROP)
        else $error("error result without entering drop phase");

endmodule

[sv/ifhc_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhc_out_stage
// Result register: holds one result transaction until the sink takes it and
// gives upstream ready whenever a new result can be loaded.
// ----------------------------------------------------------------------------
module ifhc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  ifhc_pkg::result_t result,
    output logic              space,
    ifhc_out_if.source        results
);

    logic              valid_reg, valid_next;
    ifhc_pkg::result_t data_reg;

    // a slot is free when empty or draining this cycle
    assign space = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.valid)
            valid_next = 1'b1;
        else if (results.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (result.valid)
            data_reg <= result;
    end

    assign results.valid        = valid_reg;
    assign results.status       = data_reg.status;
    assign results.payload_byte = data_reg.payload_byte;
    assign results.is_last      = data_reg.is_last;

    // a result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> space)
        else $error("result loaded while output stalled");

endmodule

[sv/ipc_frame_header_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_frame_header_checker_top
// Request frame header checker: collects and checks a 12-byte header, then
// passes payload bytes out, reporting the first header fault or extra data.
// ----------------------------------------------------------------------------
//  channel   kind          fields
//  bytes     valid/ready   action, rx_byte
//  results   valid/ready   status, payload_byte, is_last
//  cfg       write only    cfg_we, cfg_wdata (max_payload)
//
//  One byte transaction per cycle; a result appears in the cycle after its byte.
//  Throughput is set by the single result register: bytes are taken while it
//  is empty or being drained in the same cycle.
//  Reset (rst_n low) returns the parser to header collection and the length
//  limit to 16777216. A stalled result holds every byte back until it is
//  taken, header bytes that give no result included.
// ----------------------------------------------------------------------------
module ipc_frame_header_checker_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ifhc_pkg::LEN_W-1:0] cfg_wdata,
    ifhc_in_if.sink                    bytes,
    ifhc_out_if.source                 results
);

    logic              space;
    logic              accept;
    ifhc_pkg::result_t result;

    assign bytes.ready = space;
    assign accept      = bytes.valid && space;

    // parser
    ifhc_frame_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (bytes.action),
        .rx_byte   (bytes.rx_byte),
        .result    (result)
    );

    // result register
    ifhc_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .space   (space),
        .results (results)
    );

endmodule
